// ----- hdl/hsvnp_pkg.sv -----
// Shared types, constants and helper functions of the HSV palette classifier.
package hsvnp_pkg;

   localparam int CH_W           = 8;
   localparam int COL_W          = 12;
   localparam int WIDTH_W        = 13;
   localparam int IDX_W          = 3;
   localparam int DIST_W         = 10;
   localparam int PAL_SIZE       = 8;
   localparam int REM_W          = 16;
   localparam int QUO_W          = 8;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;
   localparam int MATCH_STAGES   = 3;
   localparam int PIPE_STAGES    = 1 + DIV_STAGES + MATCH_STAGES;

   localparam logic [CH_W-1:0]    WHITE_LEVEL   = 8'd250;
   localparam logic [CH_W-1:0]    HUE_STEP      = 8'd43;
   localparam logic [CH_W-1:0]    HUE_OFF_RED   = 8'd0;
   localparam logic [CH_W-1:0]    HUE_OFF_GREEN = 8'd85;
   localparam logic [CH_W-1:0]    HUE_OFF_BLUE  = 8'd171;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 13'd4096;
   localparam logic [DIST_W-1:0]  DIST_MAX      = 10'd765;

   localparam logic [IDX_W-1:0] IDX_WHITE_LEFT  = 3'd1;
   localparam logic [IDX_W-1:0] IDX_WHITE_RIGHT = 3'd2;

   // Palette in HSV, precomputed with the same integer conversion as the pixels.
   localparam logic [CH_W-1:0] PAL_H [PAL_SIZE] =
      '{8'd0, 8'd201, 8'd116, 8'd144, 8'd29, 8'd40, 8'd144, 8'd2};
   localparam logic [CH_W-1:0] PAL_S [PAL_SIZE] =
      '{8'd0, 8'd255, 8'd255, 8'd160, 8'd255, 8'd184, 8'd255, 8'd237};
   localparam logic [CH_W-1:0] PAL_V [PAL_SIZE] =
      '{8'd0, 8'd211, 8'd158, 8'd233, 8'd230, 8'd240, 8'd178, 8'd229};

   typedef enum logic [1:0] {
      HUE_RED,
      HUE_GREEN,
      HUE_BLUE
   } hue_sel_type;

   typedef struct packed {
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] span;
      hue_sel_type     sel;
      logic            neg;
      logic [CH_W-1:0] mag;
      logic            white;
      logic            left;
   } front_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   typedef struct packed {
      div_type         s;
      div_type         h;
      logic [CH_W-1:0] mx;
      logic [CH_W-1:0] span;
      hue_sel_type     sel;
      logic            neg;
      logic            white;
      logic            left;
   } div_stage_type;

   typedef struct packed {
      logic [CH_W-1:0] h;
      logic [CH_W-1:0] s;
      logic [CH_W-1:0] v;
   } hsv_type;

   // One restoring long-division step for quotient bit pos.
   function automatic div_type div_bit(div_type x, logic [CH_W-1:0] d, logic [2:0] pos);
      logic [REM_W-1:0] trial;
      div_type          y;
      trial = REM_W'(d) << pos;
      y     = x;
      if (x.rem >= trial) begin
         y.rem      = x.rem - trial;
         y.quo[pos] = 1'b1;
      end
      return y;
   endfunction

   function automatic logic [CH_W-1:0] absdiff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- hdl/hsv_nearest_palette_classifier_top.sv -----
// Top level of the HSV nearest-palette pixel classifier.
//
//  port group   dir   handshake             payload
//  req_*        in    req_valid/req_stall   red, green, blue (8b), column (12b)
//  rsp_*        out   rsp_valid/rsp_stall   palette_index (3b), best_distance (10b)
//  csr_*        in    csr_write_enable      csr_write_data = image_width (13b)
//
//  One item per cycle sustained while rsp_stall stays low; eight register stages.
//  The two restoring dividers (saturation and hue) resolve two quotient bits per
//  stage over four stages; front, HSV, distance and select stages complete the
//  pipeline.
//  Reset is synchronous and clears the stage valid bits and sets image_width to 4096.
//  A stall on rsp_stall only backs up full stages: bubbles collapse, so input is
//  still taken while a finished item waits at the output and any stage is empty.
module hsv_nearest_palette_classifier_top
   import hsvnp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CH_W-1:0]    req_red,
   input  logic [CH_W-1:0]    req_green,
   input  logic [CH_W-1:0]    req_blue,
   input  logic [COL_W-1:0]   req_column,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_palette_index,
   output logic [DIST_W-1:0]  rsp_best_distance,

   input  logic               csr_write_enable,
   input  logic [WIDTH_W-1:0] csr_write_data
);

   logic [WIDTH_W-1:0]     width_ff;
   logic [PIPE_STAGES-1:0] v_ff;
   logic [PIPE_STAGES-1:0] v_in;
   logic [PIPE_STAGES-1:0] load;
   logic [PIPE_STAGES-1:0] v_prev;
   front_type              front_q;
   div_stage_type          div_q;

   // Width register; half of it (truncated) splits near-white pixels.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_write_enable) begin
         width_ff <= csr_write_data;
      end
   end

   // Advance a stage when it is empty or its successor advances.
   always_comb begin
      load[PIPE_STAGES-1] = !v_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
      v_prev = {v_ff[PIPE_STAGES-2:0], req_valid};
      for (int k = 0; k < PIPE_STAGES; k++) begin
         v_in[k] = load[k] ? v_prev[k] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = v_ff[PIPE_STAGES-1];

   hsvnp_front u_front (
      .clock      (clock),
      .en         (load[0]),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .column     (req_column),
      .half_width (width_ff[WIDTH_W-1:1]),
      .front_q    (front_q)
   );

   hsvnp_divider u_divider (
      .clock   (clock),
      .en      (load[DIV_STAGES:1]),
      .front_q (front_q),
      .div_q   (div_q)
   );

   hsvnp_matcher u_matcher (
      .clock         (clock),
      .en            (load[PIPE_STAGES-1:DIV_STAGES+1]),
      .div_q         (div_q),
      .palette_index (rsp_palette_index),
      .best_distance (rsp_best_distance)
   );

`ifndef SYNTHESIS
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v_ff[0])
      else $error("accepted item did not reach the front stage");

   a_full_backs_up: assert property (@(posedge clock) disable iff (reset)
      ((&v_ff) && rsp_stall) |-> req_stall)
      else $error("input taken while every stage is full and output stalled");

   a_empty_out_takes: assert property (@(posedge clock) disable iff (reset)
      !v_ff[PIPE_STAGES-1] |-> !req_stall)
      else $error("input stalled although the output stage is empty");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_best_distance <= DIST_MAX))
      else $error("best distance out of range");
`endif

endmodule

// ----- hdl/hsvnp_front.sv -----
// Front stage: channel max/min, hue sector, white detect and column split.
module hsvnp_front
   import hsvnp_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [CH_W-1:0]    red,
   input  logic [CH_W-1:0]    green,
   input  logic [CH_W-1:0]    blue,
   input  logic [COL_W-1:0]   column,
   input  logic [COL_W-1:0]   half_width,
   output front_type          front_q
);

   logic [CH_W-1:0]   mx;
   logic [CH_W-1:0]   mn;
   logic signed [8:0] num;
   front_type         front_in;
   front_type         front_ff;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;

      front_in.mx   = mx;
      front_in.span = mx - mn;

      // red wins a tied maximum, then green
      priority if (mx == red) front_in.sel = HUE_RED;
      else if (mx == green)   front_in.sel = HUE_GREEN;
      else                    front_in.sel = HUE_BLUE;

      unique case (front_in.sel)
         HUE_RED:   num = $signed({1'b0, green}) - $signed({1'b0, blue});
         HUE_GREEN: num = $signed({1'b0, blue}) - $signed({1'b0, red});
         HUE_BLUE:  num = $signed({1'b0, red}) - $signed({1'b0, green});
         default:   num = '0;
      endcase

      front_in.neg   = num[8];
      front_in.mag   = num[8] ? CH_W'(-num) : CH_W'(num);
      front_in.white = (red > WHITE_LEVEL) && (green > WHITE_LEVEL) && (blue > WHITE_LEVEL);
      front_in.left  = column < half_width;
   end

   always_ff @(posedge clock) begin
      if (en) front_ff <= front_in;
   end

   assign front_q = front_ff;

endmodule

// ----- hdl/hsvnp_divider.sv -----
// Pipelined restoring dividers for saturation and hue, two quotient bits per stage.
module hsvnp_divider
   import hsvnp_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] en,
   input  front_type             front_q,
   output div_stage_type         div_q
);

   div_stage_type src      [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];
   div_stage_type stage_ff [DIV_STAGES];

   // Dividends: 255 * span for saturation, 43 * |num| for hue.
   // Later stages take the previous stage register.
   always_comb begin
      src[0].s.rem = {front_q.span, 8'b0} - REM_W'(front_q.span);
      src[0].s.quo = '0;
      src[0].h.rem = REM_W'(front_q.mag) * REM_W'(HUE_STEP);
      src[0].h.quo = '0;
      src[0].mx    = front_q.mx;
      src[0].span  = front_q.span;
      src[0].sel   = front_q.sel;
      src[0].neg   = front_q.neg;
      src[0].white = front_q.white;
      src[0].left  = front_q.left;
      for (int k = 1; k < DIV_STAGES; k++) begin
         src[k] = stage_ff[k-1];
      end
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      always_comb begin
         stage_in[k] = src[k];
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            stage_in[k].s = div_bit(stage_in[k].s, src[k].mx,
                                    3'(QUO_W - 1 - BITS_PER_STAGE * k - b));
            stage_in[k].h = div_bit(stage_in[k].h, src[k].span,
                                    3'(QUO_W - 1 - BITS_PER_STAGE * k - b));
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) stage_ff[k] <= stage_in[k];
      end
   end

   assign div_q = stage_ff[DIV_STAGES-1];

endmodule

// ----- hdl/hsvnp_matcher.sv -----
// Back stages: finish HSV, palette distances, nearest-entry select with white bypass.
module hsvnp_matcher
   import hsvnp_pkg::*;
(
   input  logic                    clock,
   input  logic [MATCH_STAGES-1:0] en,
   input  div_stage_type           div_q,
   output logic [IDX_W-1:0]        palette_index,
   output logic [DIST_W-1:0]       best_distance
);

   logic [CH_W-1:0]   off;
   logic [CH_W-1:0]   hq;
   hsv_type           hsv_in;
   hsv_type           hsv_ff;
   logic              white_a_ff;
   logic              left_a_ff;

   logic [DIST_W-1:0] dist_in [PAL_SIZE];
   logic [DIST_W-1:0] dist_ff [PAL_SIZE];
   logic              white_b_ff;
   logic              left_b_ff;

   logic [IDX_W-1:0]  i1 [4];
   logic [DIST_W-1:0] d1 [4];
   logic [IDX_W-1:0]  i2 [2];
   logic [DIST_W-1:0] d2 [2];
   logic [IDX_W-1:0]  idx_in;
   logic [DIST_W-1:0] best_in;
   logic [IDX_W-1:0]  idx_ff;
   logic [DIST_W-1:0] best_ff;

   // Stage A: signed quotient plus sector offset, wrapped to eight bits.
   always_comb begin
      unique case (div_q.sel)
         HUE_RED:   off = HUE_OFF_RED;
         HUE_GREEN: off = HUE_OFF_GREEN;
         HUE_BLUE:  off = HUE_OFF_BLUE;
         default:   off = HUE_OFF_RED;
      endcase
      hq       = div_q.neg ? (CH_W'(0) - div_q.h.quo) : div_q.h.quo;
      hsv_in.v = div_q.mx;
      if (div_q.span == '0) begin
         // gray or black: no hue, no saturation
         hsv_in.h = '0;
         hsv_in.s = '0;
      end else begin
         hsv_in.h = off + hq;
         hsv_in.s = div_q.s.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hsv_ff     <= hsv_in;
         white_a_ff <= div_q.white;
         left_a_ff  <= div_q.left;
      end
   end

   // Stage B: L1 distance to every palette entry.
   always_comb begin
      for (int p = 0; p < PAL_SIZE; p++) begin
         dist_in[p] = DIST_W'(absdiff(hsv_ff.h, PAL_H[p]))
                    + DIST_W'(absdiff(hsv_ff.s, PAL_S[p]))
                    + DIST_W'(absdiff(hsv_ff.v, PAL_V[p]));
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dist_ff    <= dist_in;
         white_b_ff <= white_a_ff;
         left_b_ff  <= left_a_ff;
      end
   end

   // Stage C: minimum tree; the upper entry wins only when strictly nearer.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (dist_ff[2*j+1] < dist_ff[2*j]) begin
            i1[j] = IDX_W'(2*j+1);
            d1[j] = dist_ff[2*j+1];
         end else begin
            i1[j] = IDX_W'(2*j);
            d1[j] = dist_ff[2*j];
         end
      end
      for (int j = 0; j < 2; j++) begin
         if (d1[2*j+1] < d1[2*j]) begin
            i2[j] = i1[2*j+1];
            d2[j] = d1[2*j+1];
         end else begin
            i2[j] = i1[2*j];
            d2[j] = d1[2*j];
         end
      end
      if (white_b_ff) begin
         idx_in  = left_b_ff ? IDX_WHITE_LEFT : IDX_WHITE_RIGHT;
         best_in = '0;
      end else if (d2[1] < d2[0]) begin
         idx_in  = i2[1];
         best_in = d2[1];
      end else begin
         idx_in  = i2[0];
         best_in = d2[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         idx_ff  <= idx_in;
         best_ff <= best_in;
      end
   end

   assign palette_index = idx_ff;
   assign best_distance = best_ff;

endmodule
